// File: rtl/core/ctc_gd_pkg.sv
// Package with the types, constants and symbol lookup of the CTC greedy decoder.
package ctc_gd_pkg;

  localparam int NUM_CLASSES_DEF = 29;
  localparam int SCORE_BITS_DEF  = 16;
  localparam int IN_SCORE_W      = 16;
  localparam int CLASS_W         = 5;
  localparam int CHAR_W          = 8;
  localparam int SYMBOL_COUNT    = 28;

  localparam logic [CLASS_W-1:0] BLANK_RESET = CLASS_W'(28);
  localparam logic [CLASS_W-1:0] PREV_RESET  = CLASS_W'(28);

  localparam logic [CLASS_W-1:0] LAST_LETTER_CLASS = CLASS_W'(26);
  localparam logic [CLASS_W-1:0] APOSTROPHE_CLASS  = CLASS_W'(27);
  localparam logic [CHAR_W-1:0]  CHAR_SPACE        = 8'h20;
  localparam logic [CHAR_W-1:0]  CHAR_APOSTROPHE   = 8'h27;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_BASE  = 8'h60;
  localparam logic [CHAR_W-1:0]  CHAR_NONE         = 8'h00;

  typedef struct packed {
    logic signed [IN_SCORE_W-1:0] score;
    logic                         sequence_end;
  } ctc_gd_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic [CLASS_W-1:0] class_index;
    logic               char_valid;
    logic               utterance_done;
  } ctc_gd_out_t;

  // Frame outcome handed from the argmax stage to the collapse stage.
  typedef struct packed {
    logic               done;
    logic               last;
    logic [CLASS_W-1:0] best_class;
  } ctc_gd_frame_t;

  // Alphabet: space, 'a' to 'z', apostrophe. Classes past the alphabet map to zero.
  function automatic logic [CHAR_W-1:0] symbol_of(input logic [CLASS_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    if (idx == '0) begin
      ch = CHAR_SPACE;
    end else if (idx <= LAST_LETTER_CLASS) begin
      ch = CHAR_LETTER_BASE + CHAR_W'(idx);
    end else if (idx == APOSTROPHE_CLASS) begin
      ch = CHAR_APOSTROPHE;
    end else begin
      ch = CHAR_NONE;
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/ctc_gd_argmax.sv
// Running argmax over the scores of one frame, with the class position counter.
module ctc_gd_argmax #(
  parameter int NUM_CLASSES = ctc_gd_pkg::NUM_CLASSES_DEF,
  parameter int SCORE_BITS  = ctc_gd_pkg::SCORE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic signed [ctc_gd_pkg::IN_SCORE_W-1:0] score,
  input  logic                                      last,
  input  logic                                      advance,
  output ctc_gd_pkg::ctc_gd_frame_t                 frame
);

  localparam int CW = ctc_gd_pkg::CLASS_W;
  localparam logic [CW-1:0] LAST_POS = CW'(NUM_CLASSES - 1);

  logic [CW-1:0]                class_count;
  logic signed [SCORE_BITS-1:0] best_score;
  logic [CW-1:0]                best_class;

  logic signed [SCORE_BITS-1:0] score_ext;
  logic                         take;
  logic [CW-1:0]                best_class_next;
  logic                         frame_end;

  // Narrow formats sign-extend from their own top bit; wider ones zero-extend the 16 input bits.
  generate
    if (SCORE_BITS <= ctc_gd_pkg::IN_SCORE_W) begin : g_narrow
      assign score_ext = signed'(score[SCORE_BITS-1:0]);
    end else begin : g_wide
      assign score_ext = signed'({{(SCORE_BITS - ctc_gd_pkg::IN_SCORE_W){1'b0}}, score});
    end
  endgenerate

  assign take            = (class_count == '0) || (score_ext > best_score);
  assign best_class_next = take ? class_count : best_class;
  assign frame_end       = (class_count >= LAST_POS) || last;

  always_comb begin
    frame.done       = frame_end;
    frame.last       = last;
    frame.best_class = best_class_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= '0;
      best_score  <= '0;
      best_class  <= '0;
    end else if (advance) begin
      if (take) begin
        best_score <= score_ext;
      end
      best_class  <= best_class_next;
      class_count <= frame_end ? '0 : class_count + CW'(1);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    class_count <= LAST_POS)
    else $error("class counter passed the last class of a frame");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    advance && frame_end |=> class_count == '0)
    else $error("class counter did not restart after a frame end");

endmodule

// File: rtl/core/ctc_gd_collapse.sv
// Symbol lookup and CTC collapse: repeats are dropped first, then the blank.
module ctc_gd_collapse (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ctc_gd_pkg::CLASS_W-1:0]      blank_class,
  input  ctc_gd_pkg::ctc_gd_frame_t           frame,
  input  logic                                advance,
  output ctc_gd_pkg::ctc_gd_out_t             result
);

  logic [ctc_gd_pkg::CLASS_W-1:0] previous_class;
  logic                           has_sym;

  assign has_sym = frame.best_class < ctc_gd_pkg::CLASS_W'(ctc_gd_pkg::SYMBOL_COUNT);

  always_comb begin
    result.character      = ctc_gd_pkg::symbol_of(frame.best_class);
    result.class_index    = frame.best_class;
    result.char_valid     = has_sym && (frame.best_class != blank_class)
                            && (frame.best_class != previous_class);
    result.utterance_done = frame.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_class <= ctc_gd_pkg::PREV_RESET;
    end else if (advance && frame.done) begin
      previous_class <= frame.last ? ctc_gd_pkg::PREV_RESET : frame.best_class;
    end
  end

  a_prev_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && frame.done && frame.last |=> previous_class == ctc_gd_pkg::PREV_RESET)
    else $error("previous class not cleared at utterance end");

endmodule

// File: rtl/core/ctc_greedy_decoder.sv
// A frame result passes the input register and then the result register before it is offered on out_valid.
// Throughput: one score beat per cycle; the input register and the result register
// decouple the channels, so scores keep flowing while a result waits.
// Only a frame-ending score stalls, and only while the result register is full and out_ready is low.
// Reset (rst, synchronous): counters and argmax cleared, previous class and blank set to 28.
module ctc_greedy_decoder #(
  parameter int NUM_CLASSES = ctc_gd_pkg::NUM_CLASSES_DEF,
  parameter int SCORE_BITS  = ctc_gd_pkg::SCORE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ctc_gd_pkg::CLASS_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ctc_gd_pkg::ctc_gd_in_t            in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ctc_gd_pkg::ctc_gd_out_t           out_data
);

  logic [ctc_gd_pkg::CLASS_W-1:0] blank_class;
  logic                           in_valid_r;
  ctc_gd_pkg::ctc_gd_in_t         in_data_r;

  ctc_gd_pkg::ctc_gd_frame_t      frame;
  ctc_gd_pkg::ctc_gd_out_t        result;
  logic                           advance;

  // The held beat moves on unless it ends a frame and the result register is blocked.
  assign advance  = in_valid_r && (!frame.done || !out_valid || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_class <= ctc_gd_pkg::BLANK_RESET;
    end else if (cfg_we) begin
      blank_class <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  ctc_gd_argmax #(
    .NUM_CLASSES(NUM_CLASSES),
    .SCORE_BITS (SCORE_BITS)
  ) u_argmax (
    .clk    (clk),
    .rst    (rst),
    .score  (in_data_r.score),
    .last   (in_data_r.sequence_end),
    .advance(advance),
    .frame  (frame)
  );

  ctc_gd_collapse u_collapse (
    .clk        (clk),
    .rst        (rst),
    .blank_class(blank_class),
    .frame      (frame),
    .advance    (advance),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && frame.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.done) begin
      out_data <= result;
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && frame.done |=> out_valid)
    else $error("frame end did not load the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && frame.done))
    else $error("waiting result overwritten");

  a_blank_suppressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.char_valid |-> out_data.class_index != blank_class)
    else $error("blank class marked as a new character");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the CTC greedy decoder: frame argmax, symbol lookup and collapse.
`timescale 1ns / 100ps

module tb;

  localparam int CLASSES = ctc_gd_pkg::NUM_CLASSES_DEF;
  localparam int CW      = ctc_gd_pkg::CLASS_W;
  localparam int SW      = ctc_gd_pkg::IN_SCORE_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  ctc_gd_pkg::ctc_gd_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ctc_gd_pkg::ctc_gd_out_t out_data;

  ctc_greedy_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Decoder state as the testbench sees it.
  string alphabet = " abcdefghijklmnopqrstuvwxyz'";
  logic [CW-1:0] blank_sel = ctc_gd_pkg::BLANK_RESET;
  logic [CW-1:0] frame_pos = '0;
  logic signed [SW-1:0] top_score = '0;
  logic [CW-1:0] top_class = '0;
  logic [CW-1:0] prior_class = ctc_gd_pkg::PREV_RESET;

  ctc_gd_pkg::ctc_gd_out_t expected_chars[$];
  ctc_gd_pkg::ctc_gd_out_t want;
  int beats_sent = 0;
  int frames_closed = 0;
  int mismatch_count = 0;
  bit gaps_on = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Tracks the running argmax and, on a frame end, queues the decoded symbol.
  task automatic decode_beat(input logic signed [SW-1:0] s, input logic seq_end);
    ctc_gd_pkg::ctc_gd_out_t res;
    logic [CW-1:0] pos;
    pos = frame_pos;
    if (pos == 0 || s > top_score) begin
      top_score = s;
      top_class = pos;
    end
    if (pos >= CLASSES - 1 || seq_end) begin
      res.class_index = top_class;
      res.character = (top_class < ctc_gd_pkg::SYMBOL_COUNT) ? alphabet[top_class]
                                                             : ctc_gd_pkg::CHAR_NONE;
      res.char_valid = (top_class < ctc_gd_pkg::SYMBOL_COUNT) && (top_class != blank_sel) &&
                       (top_class != prior_class);
      res.utterance_done = seq_end;
      prior_class = seq_end ? ctc_gd_pkg::PREV_RESET : top_class;
      frame_pos = '0;
      expected_chars.push_back(res);
      frames_closed++;
    end else begin
      frame_pos = pos + 1'b1;
    end
  endtask

  task automatic send_score(input logic signed [SW-1:0] s, input logic seq_end);
    ctc_gd_pkg::ctc_gd_in_t beat;
    beat.score = s;
    beat.sequence_end = seq_end;
    while (gaps_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    decode_beat(s, seq_end);
    beats_sent++;
  endtask

  // One frame peaking at the given class; without noise no other score exceeds it.
  task automatic send_frame(input int winner, input int length, input bit ends_utt,
                            input bit noise, input logic signed [SW-1:0] peak);
    logic signed [SW-1:0] s;
    for (int k = 0; k < length; k++) begin
      if (noise)
        s = SW'($urandom);
      else if (k == winner)
        s = peak;
      else
        s = SW'(-32768 + $urandom_range(int'(peak) + 32768));
      send_score(s, ends_utt && k == length - 1);
    end
  endtask

  // Waits until the decoder has drained before touching the blank register.
  task automatic write_blank(input logic [CW-1:0] value);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    blank_sel = value;
  endtask

  task automatic test_score_extremes;
    send_score(-16'sd32768, 1'b1);
    send_score(16'sd32767, 1'b0);
    send_score(16'sd32767, 1'b0);
    send_score(-16'sd32768, 1'b1);
    send_score(-16'sd32768, 1'b0);
    send_score(-16'sd1, 1'b0);
    send_score(16'sd0, 1'b0);
    send_score(16'sd32767, 1'b1);
    send_score(-16'sd2, 1'b0);
    send_score(-16'sd1, 1'b1);
  endtask

  task automatic test_blank_and_repeat;
    write_blank(5'd0);
    send_score(16'sd5, 1'b1);
    send_frame(7, CLASSES, 1'b0, 1'b0, 16'sd32767);
    send_frame(7, CLASSES, 1'b1, 1'b0, 16'sd32767);
    send_frame(CLASSES - 1, CLASSES, 1'b1, 1'b0, 16'sd32767);
  endtask

  // Utterances biased toward repeats and blanks; the final frame sometimes ends early.
  task automatic test_random_utterances(input logic [CW-1:0] blank, input bit with_gaps,
                                        input int beat_goal, input int frame_goal);
    int start_beats;
    int start_frames;
    int frames;
    int winner;
    int last_winner;
    int length;
    int pick;
    logic signed [SW-1:0] peak;
    write_blank(blank);
    gaps_on = with_gaps;
    start_beats = beats_sent;
    start_frames = frames_closed;
    last_winner = $urandom_range(CLASSES - 1);
    while (beats_sent - start_beats < beat_goal || frames_closed - start_frames < frame_goal) begin
      frames = $urandom_range(6, 1);
      for (int f = 0; f < frames; f++) begin
        pick = $urandom_range(19);
        if (pick < 7)
          winner = last_winner;
        else if (pick < 10)
          winner = blank;
        else if (pick < 12)
          winner = CLASSES - 1;
        else
          winner = $urandom_range(CLASSES - 1);
        if (winner >= CLASSES)
          winner = $urandom_range(CLASSES - 1);
        pick = $urandom_range(9);
        if (pick == 0)
          peak = 16'sd32767;
        else if (pick == 1)
          peak = -16'sd32768;
        else
          peak = SW'($urandom);
        length = CLASSES;
        if (f == frames - 1 && $urandom_range(3) == 0)
          length = $urandom_range(CLASSES - 1, 1);
        send_frame(winner, length, f == frames - 1, $urandom_range(99) < 12, peak);
        last_winner = winner;
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : (!gaps_on || $urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_chars.pop_front();
        if (out_data.character !== want.character)
          report_mismatch($sformatf("character %h, expected %h",
                                    out_data.character, want.character));
        if (out_data.class_index !== want.class_index)
          report_mismatch($sformatf("class_index %0d, expected %0d",
                                    out_data.class_index, want.class_index));
        if (out_data.char_valid !== want.char_valid)
          report_mismatch($sformatf("char_valid %b, expected %b",
                                    out_data.char_valid, want.char_valid));
        if (out_data.utterance_done !== want.utterance_done)
          report_mismatch($sformatf("utterance_done %b, expected %b",
                                    out_data.utterance_done, want.utterance_done));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_score_extremes;
    test_blank_and_repeat;
    test_random_utterances(5'd31, 1'b1, 25, 1);
    test_random_utterances(5'd0, 1'b1, 25, 1);
    test_random_utterances(5'($urandom_range(31)), 1'b0, 25, 1);
    test_random_utterances(5'd27, 1'b1, 25, 1);
    test_random_utterances(ctc_gd_pkg::BLANK_RESET, 1'b1, 25, 1);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mismatch: run timed out");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
